### rtl/grid_maze_dfs_reachability_unit_macros.svh
// assertion macros for the grid maze reachability unit
// used by the top level only; no dependencies
`ifndef GRID_MAZE_DFS_REACHABILITY_UNIT_MACROS_SVH
`define GRID_MAZE_DFS_REACHABILITY_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define GMD_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define GMD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/gmd_pkg.sv
// shared types, constants and helpers for the grid maze reachability unit
// no dependencies
package gmd_pkg;

    localparam int GRID_DIM = 16;
    localparam int CELLS    = GRID_DIM * GRID_DIM;
    localparam int COORD_W  = $clog2(GRID_DIM);
    localparam int CELL_AW  = $clog2(CELLS);
    localparam int SP_W     = $clog2(CELLS + 1);

    localparam int FIELD_W  = 4;
    localparam int KIND_W   = 2;
    localparam int STEP_W   = 10;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 4;

    localparam logic [KIND_W-1:0] KIND_OPEN    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_BLOCKED = 2'd1;
    localparam logic [KIND_W-1:0] KIND_EXIT    = 2'd2;

    localparam logic [STEP_W-1:0] COUNT_MAX = {STEP_W{1'b1}};

    localparam logic [CFG_IDX_W-1:0] REG_START_ROW = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_COL = 1'd1;

    typedef struct packed {
        logic [FIELD_W-1:0] cell_row;
        logic [FIELD_W-1:0] cell_col;
        logic [KIND_W-1:0]  cell_kind;
        logic               last_cell;
    } gmd_item_t;

    typedef struct packed {
        logic              path_found;
        logic [STEP_W-1:0] step_count;
    } gmd_result_t;

    // requests from the search controller to the grid store
    typedef struct packed {
        logic               load_we;
        logic [CELL_AW-1:0] load_addr;
        logic [KIND_W-1:0]  load_kind;
        logic [CELL_AW-1:0] rd_addr;
        logic               vis_set;
        logic [CELL_AW-1:0] vis_addr;
        logic               clear_start;
    } gmd_store_req_t;

    typedef struct packed {
        logic              clearing;
        logic [KIND_W-1:0] rd_kind;
        logic              rd_visited;
    } gmd_store_stat_t;

    function automatic logic field_in_grid(input logic [FIELD_W-1:0] f);
        return int'(f) < GRID_DIM;
    endfunction

    function automatic logic [CELL_AW-1:0] cell_addr(input logic [COORD_W-1:0] r,
                                                     input logic [COORD_W-1:0] c);
        return CELL_AW'(int'(r) * GRID_DIM + int'(c));
    endfunction

endpackage

### rtl/gmd_grid_store.sv
// grid store: cell kind memory and visited memory with a clearing sweep
// depends on gmd_pkg
module gmd_grid_store (
    input  logic                    clk,
    input  logic                    rst_n,
    input  gmd_pkg::gmd_store_req_t req,
    output gmd_pkg::gmd_store_stat_t stat
);
    import gmd_pkg::*;

    logic [KIND_W-1:0]  cell_mem [CELLS];
    logic               vis_mem  [CELLS];
    logic [KIND_W-1:0]  kind_rd_reg;
    logic               vis_rd_reg;
    logic               clr_busy_reg;
    logic               clr_busy_next;
    logic [CELL_AW-1:0] clr_addr_reg;
    logic [CELL_AW-1:0] clr_addr_next;

    always_ff @(posedge clk)
    begin
        if (req.load_we)
        begin
            cell_mem[req.load_addr] <= req.load_kind;
        end
        kind_rd_reg <= cell_mem[req.rd_addr];
    end

    // the sweep owns the write port while it runs
    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
        begin
            vis_mem[clr_addr_reg] <= 1'b0;
        end
        else if (req.vis_set)
        begin
            vis_mem[req.vis_addr] <= 1'b1;
        end
        vis_rd_reg <= vis_mem[req.rd_addr];
    end

    always_comb
    begin
        clr_busy_next = clr_busy_reg;
        clr_addr_next = clr_addr_reg;
        if (req.clear_start)
        begin
            clr_busy_next = 1'b1;
            clr_addr_next = '0;
        end
        else if (clr_busy_reg)
        begin
            if (clr_addr_reg == CELL_AW'(CELLS - 1))
            begin
                clr_busy_next = 1'b0;
            end
            else
            begin
                clr_addr_next = clr_addr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b0;
            clr_addr_reg <= '0;
        end
        else
        begin
            clr_busy_reg <= clr_busy_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    assign stat.clearing   = clr_busy_reg;
    assign stat.rd_kind    = kind_rd_reg;
    assign stat.rd_visited = vis_rd_reg;

endmodule

### rtl/grid_maze_dfs_reachability_unit.sv
// grid maze reachability unit: load controller, depth-first search sequencer, stack memory
// depends on gmd_pkg, gmd_grid_store and the assertion macro header
//
// usage: cells are loaded as beats on item, one per cycle, accepted when start is high and
// busy is low. a cell outside the grid is not stored. a beat with last_cell set is stored
// and then starts a search from the start cell set by cfg_we/cfg_index/cfg_data
// (start_row index 0, reset 1; start_col index 1, reset 0). busy stays high for the search.
// order of work: the visited memory is first cleared by a sweep that holds the search;
// then each arrival at a cell (the start, a push or a pop) passes ST_CUR_RD and ST_CUR_CK,
// each probed neighbor ST_PROBE and ST_NB_CK (only ST_PROBE if off-grid), and each pop
// ST_POP_WB first; the registered reads of the cell and visited memories set this order.
// done rises the cycle after the final decision and pulses for one cycle with result
// (path_found, step_count); busy drops in that same cycle. other cell loads give no result.
// the receiver cannot stall: done marks the result beat for a single cycle, and result holds
// until the next search starts. reset returns the controller to idle and the start registers
// to their reset values; the cell memory holds nothing defined until loaded.
module grid_maze_dfs_reachability_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  gmd_pkg::gmd_item_t            item,
    output logic                          done,
    output gmd_pkg::gmd_result_t          result,
    input  logic                          cfg_we,
    input  logic [gmd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [gmd_pkg::CFG_DATA_W-1:0] cfg_data
);
    import gmd_pkg::*;

    `include "grid_maze_dfs_reachability_unit_macros.svh"

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SWEEP  = 3'd1;
    localparam logic [2:0] ST_CUR_RD = 3'd2;
    localparam logic [2:0] ST_CUR_CK = 3'd3;
    localparam logic [2:0] ST_PROBE  = 3'd4;
    localparam logic [2:0] ST_NB_CK  = 3'd5;
    localparam logic [2:0] ST_POP_WB = 3'd6;

    localparam logic [1:0] DIR_DOWN  = 2'd0;
    localparam logic [1:0] DIR_RIGHT = 2'd1;
    localparam logic [1:0] DIR_UP    = 2'd2;
    localparam logic [1:0] DIR_LEFT  = 2'd3;

    localparam int POS_W = 2 * COORD_W;

    gmd_store_req_t  store_req;
    gmd_store_stat_t store_stat;

    logic [2:0]          state_reg,   state_next;
    logic [1:0]          dir_reg,     dir_next;
    logic [COORD_W-1:0]  cur_row_reg, cur_row_next;
    logic [COORD_W-1:0]  cur_col_reg, cur_col_next;
    logic [COORD_W-1:0]  nb_row_reg,  nb_row_next;
    logic [COORD_W-1:0]  nb_col_reg,  nb_col_next;
    logic [SP_W-1:0]     sp_reg,      sp_next;
    logic [STEP_W-1:0]   step_cnt_reg, step_cnt_next;
    logic                done_reg,    done_next;
    logic                found_reg,   found_next;
    logic [FIELD_W-1:0]  start_row_reg;
    logic [FIELD_W-1:0]  start_col_reg;

    logic [POS_W-1:0]    stack_mem [CELLS];
    logic [POS_W-1:0]    stack_rd_reg;
    logic                stack_we;
    logic                stack_re;
    logic [SP_W-1:0]     sp_dec;

    logic                accept;
    logic                nb_ok;
    logic [COORD_W-1:0]  nb_row_c;
    logic [COORD_W-1:0]  nb_col_c;
    logic [STEP_W-1:0]   step_inc;

    gmd_grid_store u_store (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (store_req),
        .stat  (store_stat)
    );

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;
    assign sp_dec = sp_reg - 1'b1;
    assign step_inc = (step_cnt_reg == COUNT_MAX) ? step_cnt_reg : step_cnt_reg + 1'b1;

    // candidate neighbor for the direction under test
    always_comb
    begin
        nb_row_c = cur_row_reg;
        nb_col_c = cur_col_reg;
        nb_ok    = 1'b0;
        unique case (dir_reg)
            DIR_DOWN:
            begin
                nb_row_c = cur_row_reg + 1'b1;
                nb_ok    = (int'(cur_row_reg) + 1) < GRID_DIM;
            end
            DIR_RIGHT:
            begin
                nb_col_c = cur_col_reg + 1'b1;
                nb_ok    = (int'(cur_col_reg) + 1) < GRID_DIM;
            end
            DIR_UP:
            begin
                nb_row_c = cur_row_reg - 1'b1;
                nb_ok    = (cur_row_reg != '0);
            end
            DIR_LEFT:
            begin
                nb_col_c = cur_col_reg - 1'b1;
                nb_ok    = (cur_col_reg != '0);
            end
        endcase
    end

    always_comb
    begin
        state_next    = state_reg;
        dir_next      = dir_reg;
        cur_row_next  = cur_row_reg;
        cur_col_next  = cur_col_reg;
        nb_row_next   = nb_row_reg;
        nb_col_next   = nb_col_reg;
        sp_next       = sp_reg;
        step_cnt_next = step_cnt_reg;
        done_next     = 1'b0;
        found_next    = found_reg;
        stack_we      = 1'b0;
        stack_re      = 1'b0;

        store_req.load_we     = 1'b0;
        store_req.load_addr   = cell_addr(COORD_W'(item.cell_row), COORD_W'(item.cell_col));
        store_req.load_kind   = item.cell_kind;
        store_req.rd_addr     = cell_addr(cur_row_reg, cur_col_reg);
        store_req.vis_set     = 1'b0;
        store_req.vis_addr    = cell_addr(cur_row_reg, cur_col_reg);
        store_req.clear_start = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    store_req.load_we = field_in_grid(item.cell_row) &&
                                        field_in_grid(item.cell_col);
                    if (item.last_cell)
                    begin
                        store_req.clear_start = 1'b1;
                        sp_next       = '0;
                        step_cnt_next = '0;
                        state_next    = ST_SWEEP;
                    end
                end
            end
            ST_SWEEP:
            begin
                if (!store_stat.clearing)
                begin
                    if (field_in_grid(start_row_reg) && field_in_grid(start_col_reg))
                    begin
                        cur_row_next = COORD_W'(start_row_reg);
                        cur_col_next = COORD_W'(start_col_reg);
                        state_next   = ST_CUR_RD;
                    end
                    else
                    begin
                        cur_row_next = '0;
                        cur_col_next = '0;
                        found_next   = 1'b0;
                        done_next    = 1'b1;
                        state_next   = ST_IDLE;
                    end
                end
            end
            ST_CUR_RD:
            begin
                state_next = ST_CUR_CK;
            end
            ST_CUR_CK:
            begin
                if (store_stat.rd_kind == KIND_EXIT)
                begin
                    found_next = 1'b1;
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    store_req.vis_set = 1'b1;
                    dir_next   = DIR_DOWN;
                    state_next = ST_PROBE;
                end
            end
            ST_PROBE:
            begin
                if (nb_ok)
                begin
                    store_req.rd_addr = cell_addr(nb_row_c, nb_col_c);
                    nb_row_next = nb_row_c;
                    nb_col_next = nb_col_c;
                    state_next  = ST_NB_CK;
                end
                else if (dir_reg != DIR_LEFT)
                begin
                    dir_next = dir_reg + 1'b1;
                end
                else if (sp_reg == '0)
                begin
                    found_next = 1'b0;
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    stack_re   = 1'b1;
                    sp_next    = sp_dec;
                    state_next = ST_POP_WB;
                end
            end
            ST_NB_CK:
            begin
                if (store_stat.rd_kind != KIND_BLOCKED && !store_stat.rd_visited)
                begin
                    cur_row_next  = nb_row_reg;
                    cur_col_next  = nb_col_reg;
                    step_cnt_next = step_inc;
                    if (int'(sp_reg) < CELLS)
                    begin
                        stack_we = 1'b1;
                        sp_next  = sp_reg + 1'b1;
                    end
                    state_next = ST_CUR_RD;
                end
                else if (dir_reg != DIR_LEFT)
                begin
                    dir_next   = dir_reg + 1'b1;
                    state_next = ST_PROBE;
                end
                else if (sp_reg == '0)
                begin
                    found_next = 1'b0;
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    stack_re   = 1'b1;
                    sp_next    = sp_dec;
                    state_next = ST_POP_WB;
                end
            end
            ST_POP_WB:
            begin
                cur_row_next  = stack_rd_reg[POS_W-1:COORD_W];
                cur_col_next  = stack_rd_reg[COORD_W-1:0];
                step_cnt_next = step_inc;
                state_next    = ST_CUR_RD;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // position stack: one write port for pushes, one registered read for pops
    always_ff @(posedge clk)
    begin
        if (stack_we)
        begin
            stack_mem[sp_reg[CELL_AW-1:0]] <= {nb_row_reg, nb_col_reg};
        end
        if (stack_re)
        begin
            stack_rd_reg <= stack_mem[sp_dec[CELL_AW-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            dir_reg       <= DIR_DOWN;
            cur_row_reg   <= '0;
            cur_col_reg   <= '0;
            nb_row_reg    <= '0;
            nb_col_reg    <= '0;
            sp_reg        <= '0;
            step_cnt_reg  <= '0;
            done_reg      <= 1'b0;
            found_reg     <= 1'b0;
            start_row_reg <= FIELD_W'(1);
            start_col_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            dir_reg      <= dir_next;
            cur_row_reg  <= cur_row_next;
            cur_col_reg  <= cur_col_next;
            nb_row_reg   <= nb_row_next;
            nb_col_reg   <= nb_col_next;
            sp_reg       <= sp_next;
            step_cnt_reg <= step_cnt_next;
            done_reg     <= done_next;
            found_reg    <= found_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_START_ROW: start_row_reg <= cfg_data;
                    REG_START_COL: start_col_reg <= cfg_data;
                endcase
            end
        end
    end

    assign done              = done_reg;
    assign result.path_found = found_reg;
    assign result.step_count = step_cnt_reg;

    `GMD_ASSERT_NEXT(a_done_single, clk, rst_n, done, !done, "result strobe longer than one cycle")
    `GMD_ASSERT_NEXT(a_last_starts, clk, rst_n, accept && item.last_cell, busy, "last cell beat did not start a search")
    `GMD_ASSERT_NEXT(a_count_sat, clk, rst_n, busy && step_cnt_reg == COUNT_MAX, step_cnt_reg == COUNT_MAX, "step count left saturation during a search")

endmodule

### sim/maze_walk_checker.sv
// checker for the grid maze reachability unit: mirrors the cell grid and the start registers,
// walks the maze on each search beat and compares every result beat in order
// depends on gmd_pkg
module maze_walk_checker
    import gmd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  busy,
    input  gmd_item_t             item,
    input  logic                  done,
    input  gmd_result_t           result,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    mismatches,
    output int                    pending
);

    logic [KIND_W-1:0]     kind_map [CELLS];
    logic [CFG_DATA_W-1:0] origin_row;
    logic [CFG_DATA_W-1:0] origin_col;
    gmd_result_t           verdicts_due [$];

    // off-grid neighbors count as walls; spare kind is passable
    function automatic bit can_step(int r, int c, logic [CELLS-1:0] seen);
        int at;
        if (r >= GRID_DIM || c >= GRID_DIM)
            return 1'b0;
        at = r * GRID_DIM + c;
        return kind_map[at] != KIND_BLOCKED && !seen[at];
    endfunction

    function automatic gmd_result_t walk_maze();
        int               here;
        int               trail [CELLS];
        logic [CELLS-1:0] seen;
        int               depth;
        int               steps;
        int               r;
        int               c;
        int               nr;
        int               nc;
        bit               finished;
        bit               moved;
        gmd_result_t      res;
        res      = '0;
        seen     = '0;
        depth    = 0;
        steps    = 0;
        finished = 1'b0;
        here     = 0;
        if (int'(origin_row) >= GRID_DIM || int'(origin_col) >= GRID_DIM)
            finished = 1'b1;
        else
            here = int'(origin_row) * GRID_DIM + int'(origin_col);
        while (!finished)
        begin
            r = here / GRID_DIM;
            c = here % GRID_DIM;
            if (kind_map[here] == KIND_EXIT)
            begin
                res.path_found = 1'b1;
                finished = 1'b1;
            end
            else
            begin
                // start cell kind is never tested for walls
                seen[here] = 1'b1;
                moved = 1'b1;
                nr = r;
                nc = c;
                if (can_step(r + 1, c, seen))
                    nr = r + 1;
                else if (can_step(r, c + 1, seen))
                    nc = c + 1;
                else if (r > 0 && can_step(r - 1, c, seen))
                    nr = r - 1;
                else if (c > 0 && can_step(r, c - 1, seen))
                    nc = c - 1;
                else
                    moved = 1'b0;
                if (moved)
                begin
                    here = nr * GRID_DIM + nc;
                    if (depth < CELLS)
                    begin
                        trail[depth] = here;
                        depth++;
                    end
                    if (steps < int'(COUNT_MAX))
                        steps++;
                end
                else if (depth == 0)
                    finished = 1'b1;
                else
                begin
                    // top of the trail is the current cell, so the first pop stays put
                    depth--;
                    here = trail[depth];
                    if (steps < int'(COUNT_MAX))
                        steps++;
                end
            end
        end
        res.step_count = STEP_W'(steps);
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        gmd_result_t want;
        if (!rst_n)
        begin
            verdicts_due.delete();
            origin_row = CFG_DATA_W'(1);
            origin_col = '0;
            mismatches = 0;
            pending    = 0;
        end
        else
        begin
            if (done)
            begin
                if (verdicts_due.size() == 0)
                begin
                    $error("result beat with nothing expected: path_found %0d step_count %0d",
                           result.path_found, result.step_count);
                    mismatches++;
                end
                else
                begin
                    want = verdicts_due.pop_front();
                    if (result.path_found !== want.path_found)
                    begin
                        $error("path_found expected %0d actual %0d",
                               want.path_found, result.path_found);
                        mismatches++;
                    end
                    if (result.step_count !== want.step_count)
                    begin
                        $error("step_count expected %0d actual %0d",
                               want.step_count, result.step_count);
                        mismatches++;
                    end
                end
            end
            if (cfg_we)
            begin
                if (cfg_index == REG_START_ROW)
                    origin_row = cfg_data;
                else if (cfg_index == REG_START_COL)
                    origin_col = cfg_data;
            end
            if (start && !busy)
            begin
                if (int'(item.cell_row) < GRID_DIM && int'(item.cell_col) < GRID_DIM)
                    kind_map[int'(item.cell_row) * GRID_DIM + int'(item.cell_col)] = item.cell_kind;
                if (item.last_cell)
                    verdicts_due.push_back(walk_maze());
            end
            pending = verdicts_due.size();
        end
    end

endmodule

### sim/grid_maze_dfs_reachability_unit_test.sv
// testbench top for the grid maze reachability unit: loads cell beats, moves the start cell
// between searches and gives the verdict from the checker's counts
// depends on gmd_pkg, grid_maze_dfs_reachability_unit and maze_walk_checker
module grid_maze_dfs_reachability_unit_test;
    import gmd_pkg::*;

    localparam int RANDOM_ITEMS  = 1180;
    localparam int MIN_SEARCHES  = 40;
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 400;
    localparam int RUN_LIMIT     = 100000000;
    localparam int EDGE          = GRID_DIM - 1;
    localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    gmd_item_t             item;
    logic                  done;
    gmd_result_t           result;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    mismatches;
    int                    pending;
    int                    idle_pct;
    int                    sent;
    int                    searches;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    grid_maze_dfs_reachability_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    maze_walk_checker u_walk_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .item       (item),
        .done       (done),
        .result     (result),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .pending    (pending)
    );

    function automatic gmd_item_t make_cell(int r, int c, logic [KIND_W-1:0] k, bit last);
        gmd_item_t beat;
        beat.cell_row  = FIELD_W'(r);
        beat.cell_col  = FIELD_W'(c);
        beat.cell_kind = k;
        beat.last_cell = last;
        return beat;
    endfunction

    // exits stay rare so most searches wander far before ending
    function automatic logic [KIND_W-1:0] pick_kind(int blocked_pct);
        int v;
        v = $urandom_range(999);
        if (v < 10)
            return KIND_EXIT;
        if (v < 50)
            return KIND_SPARE;
        if ($urandom_range(99) < blocked_pct)
            return KIND_BLOCKED;
        return KIND_OPEN;
    endfunction

    function automatic int pick_coord();
        case ($urandom_range(3))
            0:       return 0;
            1:       return EDGE;
            default: return $urandom_range(EDGE);
        endcase
    endfunction

    // present one beat, holding start until the unit takes it
    task automatic push_cell(input gmd_item_t beat);
        int gap;
        gap = 0;
        if ($urandom_range(99) < idle_pct)
            gap = $urandom_range(1, ($urandom_range(7) == 0) ? 12 : 3);
        @(negedge clk);
        if (gap > 0)
        begin
            start <= 1'b0;
            item  <= make_cell($urandom_range(EDGE), $urandom_range(EDGE),
                               KIND_W'($urandom_range(3)), $urandom_range(1) == 1);
            repeat (gap) @(negedge clk);
        end
        start <= 1'b1;
        item  <= beat;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sent++;
        if (beat.last_cell)
            searches++;
    endtask

    task automatic settle();
        @(negedge clk);
        start <= 1'b0;
        while (pending != 0 || busy)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_start(int row, int col);
        settle();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_START_ROW;
        cfg_data  <= CFG_DATA_W'(row);
        @(negedge clk);
        cfg_index <= REG_START_COL;
        cfg_data  <= CFG_DATA_W'(col);
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial
    begin
        #(RUN_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        int r;
        int c;
        int ph;
        int len;
        int gap_at;
        int blocked_pct;
        int line;
        int quota;
        bit by_row;
        start     = 1'b0;
        item      = '0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        rst_n     = 1'b0;
        idle_pct  = 0;
        sent      = 0;
        searches  = 0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // whole grid first so no search ever reads a cell that was never loaded;
        // the closing beat searches from the reset start cell
        for (r = 0; r < GRID_DIM; r++)
            for (c = 0; c < GRID_DIM; c++)
                push_cell(make_cell(r, c, pick_kind(30), r == EDGE && c == EDGE));

        set_start(0, 0);
        // start cell is itself an exit
        push_cell(make_cell(0, 0, KIND_EXIT, 1'b1));
        // blocked start walled in by the grid edge and two walls
        push_cell(make_cell(1, 0, KIND_BLOCKED, 1'b0));
        push_cell(make_cell(0, 1, KIND_BLOCKED, 1'b0));
        push_cell(make_cell(0, 0, KIND_BLOCKED, 1'b1));
        // one step into a dead end, then back out through the stack
        push_cell(make_cell(0, 0, KIND_OPEN, 1'b0));
        push_cell(make_cell(2, 0, KIND_BLOCKED, 1'b0));
        push_cell(make_cell(1, 1, KIND_BLOCKED, 1'b0));
        push_cell(make_cell(1, 0, KIND_OPEN, 1'b1));

        // far corner with spare kind at the start, exit two moves up
        set_start(EDGE, EDGE);
        push_cell(make_cell(EDGE - 1, EDGE - 1, KIND_BLOCKED, 1'b0));
        push_cell(make_cell(EDGE, EDGE - 1, KIND_BLOCKED, 1'b0));
        push_cell(make_cell(EDGE - 1, EDGE, KIND_OPEN, 1'b0));
        push_cell(make_cell(EDGE, EDGE, KIND_SPARE, 1'b0));
        push_cell(make_cell(EDGE - 2, EDGE, KIND_EXIT, 1'b1));

        set_start(0, EDGE);
        push_cell(make_cell(0, EDGE, KIND_OPEN, 1'b1));
        set_start(EDGE, 0);
        push_cell(make_cell(EDGE, 0, KIND_SPARE, 1'b1));

        sent = 0;
        searches = 0;
        for (ph = 0; ph < 4; ph++)
        begin
            case (ph)
                1:       idle_pct = 45;
                3:       idle_pct = 32;
                default: idle_pct = 0;
            endcase
            quota = (ph + 1) * RANDOM_ITEMS / 4;
            while (sent < quota || (ph == 3 && searches < MIN_SEARCHES))
            begin
                if ($urandom_range(5) == 0)
                    set_start(pick_coord(), pick_coord());
                case ($urandom_range(9))
                    0, 1, 2, 3, 4, 5:
                    begin
                        // scattered rewrites, then search
                        blocked_pct = $urandom_range(60);
                        len = $urandom_range(4, 30);
                        for (r = 0; r < len; r++)
                            push_cell(make_cell($urandom_range(EDGE), $urandom_range(EDGE),
                                                pick_kind(blocked_pct), r == len - 1));
                    end
                    6, 7:
                    begin
                        // full wall across a row or column with one gap
                        by_row = $urandom_range(1);
                        line   = $urandom_range(EDGE);
                        gap_at = $urandom_range(EDGE);
                        for (r = 0; r < GRID_DIM; r++)
                            push_cell(make_cell(by_row ? line : r, by_row ? r : line,
                                                (r == gap_at) ? KIND_OPEN : KIND_BLOCKED,
                                                r == EDGE));
                    end
                    default:
                    begin
                        // noise: any field, searches at random points
                        len = $urandom_range(1, 12);
                        for (r = 0; r < len; r++)
                            push_cell(make_cell($urandom_range(EDGE), $urandom_range(EDGE),
                                                KIND_W'($urandom_range(3)),
                                                $urandom_range(7) == 0));
                    end
                endcase
            end
        end

        settle();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (mismatches == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

### grid_maze_dfs_reachability_unit.f
+incdir+rtl
rtl/gmd_pkg.sv
rtl/gmd_grid_store.sv
rtl/grid_maze_dfs_reachability_unit.sv
sim/maze_walk_checker.sv
sim/grid_maze_dfs_reachability_unit_test.sv
